// File: rtl/core/rqr_pkg.sv
// ----------------------------------------------------------------------------
// rqr_pkg
// shared types and constants for the ready queue with removal
// ----------------------------------------------------------------------------
package rqr_pkg;

  localparam int MaxIdsDefault = 64;
  localparam int IdW           = 6;
  localparam int CntW          = 7;
  localparam int IdSpace       = 1 << IdW;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/rqr_ctrl.sv
// ----------------------------------------------------------------------------
// rqr_ctrl
// sequencer: takes a command, then runs the link update once the result slot is free
// ----------------------------------------------------------------------------
module rqr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rqr_pkg::sts_t sts_i,
  output rqr_pkg::ctl_t ctl_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctl_o.load = 1'b0;
    ctl_o.exec = 1'b0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          ctl_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/rqr_datapath.sv
// ----------------------------------------------------------------------------
// rqr_datapath
// link memories, queued marks, head/tail/count and the result register
// ----------------------------------------------------------------------------
module rqr_datapath #(
  parameter int MAX_IDS = rqr_pkg::MaxIdsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rqr_pkg::ctl_t            ctl_i,
  output rqr_pkg::sts_t            sts_o,
  input  logic [1:0]               command_i,
  input  logic [rqr_pkg::IdW-1:0]  task_id_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [rqr_pkg::IdW-1:0]  result_id_o,
  output logic                     ok_o,
  output logic [rqr_pkg::CntW-1:0] queued_count_o,
  output logic                     is_empty_o
);

  localparam int IdW      = rqr_pkg::IdW;
  localparam int CntW     = rqr_pkg::CntW;
  localparam int NumSlots = (MAX_IDS < rqr_pkg::IdSpace) ? MAX_IDS : rqr_pkg::IdSpace;
  localparam int IdxW     = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam logic [IdW:0] SlotLim = (IdW + 1)'(NumSlots);

  logic [IdW-1:0]      next_mem [NumSlots];
  logic [IdW-1:0]      prev_mem [NumSlots];
  logic [NumSlots-1:0] mark_q, mark_d;
  logic [IdW-1:0]      head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [1:0]          cmd_q;
  logic [IdW-1:0]      id_q;
  logic [IdW-1:0]      next_rd_q, prev_rd_q;
  logic [IdW-1:0]      rd_id;

  logic                out_valid_q;
  logic [IdW-1:0]      rid_q, rid_d;
  logic                ok_q, ok_d;
  logic [CntW-1:0]     cnt_out_q;
  logic                empty_q;

  logic                next_we, prev_we;
  logic [IdxW-1:0]     next_wa, prev_wa;
  logic [IdW-1:0]      next_wd, prev_wd;

  logic                id_ok, do_push, do_unlink;
  logic [IdW-1:0]      uid;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign rd_id = (command_i == rqr_pkg::CMD_POP) ? head_q : task_id_i;

  // command latch and link read
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q     <= command_i;
      id_q      <= task_id_i;
      next_rd_q <= next_mem[rd_id[IdxW-1:0]];
      prev_rd_q <= prev_mem[rd_id[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
  end

  assign id_ok     = {1'b0, id_q} < SlotLim;
  assign uid       = (cmd_q == rqr_pkg::CMD_POP) ? head_q : id_q;
  assign do_push   = (cmd_q == rqr_pkg::CMD_PUSH) && id_ok && !mark_q[id_q[IdxW-1:0]];
  assign do_unlink = ((cmd_q == rqr_pkg::CMD_POP) && (count_q != '0)) ||
                     ((cmd_q == rqr_pkg::CMD_REMOVE) && id_ok && mark_q[id_q[IdxW-1:0]]);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    mark_d  = mark_q;
    next_we = 1'b0;
    prev_we = 1'b0;
    next_wa = tail_q[IdxW-1:0];
    prev_wa = id_q[IdxW-1:0];
    next_wd = id_q;
    prev_wd = tail_q;
    rid_d   = '0;
    ok_d    = 1'b0;
    if (ctl_i.exec && do_push) begin
      if (count_q == '0) begin
        head_d = id_q;
      end else begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      tail_d                 = id_q;
      mark_d[id_q[IdxW-1:0]] = 1'b1;
      count_d                = count_q + CntW'(1);
      rid_d                  = id_q;
      ok_d                   = 1'b1;
    end else if (ctl_i.exec && do_unlink) begin
      if (uid == head_q) begin
        head_d = next_rd_q;
      end else begin
        next_we = 1'b1;
        next_wa = prev_rd_q[IdxW-1:0];
        next_wd = next_rd_q;
      end
      if (uid == tail_q) begin
        tail_d = prev_rd_q;
      end else begin
        prev_we = 1'b1;
        prev_wa = next_rd_q[IdxW-1:0];
        prev_wd = prev_rd_q;
      end
      mark_d[uid[IdxW-1:0]] = 1'b0;
      count_d               = count_q - CntW'(1);
      if (count_d == '0) begin
        head_d = '0;
        tail_d = '0;
      end
      rid_d = uid;
      ok_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mark_q  <= mark_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (ctl_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      rid_q     <= rid_d;
      ok_q      <= ok_d;
      cnt_out_q <= count_d;
      empty_q   <= (count_d == '0);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_id_o    = rid_q;
  assign ok_o           = ok_q;
  assign queued_count_o = cnt_out_q;
  assign is_empty_o     = empty_q;

endmodule

// File: rtl/core/ready_queue_with_removal_top.sv
// ----------------------------------------------------------------------------
// ready_queue_with_removal_top
// doubly linked ready queue of task ids with push, pop and remove by id
// ----------------------------------------------------------------------------
// an input transfer latches the command and reads the link memories; the link update
//   then loads the result register once the result slot is free, and no new command
//   is taken until that update is done, as the link memory read is registered first
// reset: head, tail, count, queued marks and output valid clear at once;
//   link memories are not reset and are written before they are read
module ready_queue_with_removal_top #(
  parameter int MAX_IDS = rqr_pkg::MaxIdsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               command_i,
  input  logic [rqr_pkg::IdW-1:0]  task_id_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [rqr_pkg::IdW-1:0]  result_id_o,
  output logic                     ok_o,
  output logic [rqr_pkg::CntW-1:0] queued_count_o,
  output logic                     is_empty_o
);

  rqr_pkg::ctl_t ctl;
  rqr_pkg::sts_t sts;

  rqr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  rqr_datapath #(
    .MAX_IDS (MAX_IDS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .command_i      (command_i),
    .task_id_i      (task_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_id_o    (result_id_o),
    .ok_o           (ok_o),
    .queued_count_o (queued_count_o),
    .is_empty_o     (is_empty_o)
  );

endmodule

// File: rtl/core/rqr_checker.sv
// ----------------------------------------------------------------------------
// rqr_checker
// port level checks for the ready queue, bound to the top level
// ----------------------------------------------------------------------------
module rqr_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [rqr_pkg::IdW-1:0]  result_id_o,
  input logic                     ok_o,
  input logic [rqr_pkg::CntW-1:0] queued_count_o,
  input logic                     is_empty_o
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a command is in flight");

  a_refused_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> result_id_o == '0)
    else $error("refused command reports nonzero id");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> is_empty_o == (queued_count_o == '0))
    else $error("empty flag disagrees with count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> queued_count_o <= rqr_pkg::CntW'(rqr_pkg::IdSpace))
    else $error("count beyond id space");

endmodule

bind ready_queue_with_removal_top rqr_checker u_rqr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .result_id_o    (result_id_o),
  .ok_o           (ok_o),
  .queued_count_o (queued_count_o),
  .is_empty_o     (is_empty_o)
);
